// ===== sv/stunp_pkg.sv =====
// Shared types and constants for the STUN mapped-address parser.
package stunp_pkg;

    // Default packet size limit and fixed message layout
    localparam int MAX_PACKET_BYTES_DEF = 1024;
    localparam int HDR_BYTES            = 20;
    localparam int LIM_W                = 17;

    // Attribute codes
    localparam logic [15:0] AT_MAPPED = 16'h0001;
    localparam logic [15:0] AT_XOR    = 16'h0020;
    localparam logic [15:0] AT_MS_XOR = 16'h8020;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_MAPPED = 2'd1,
        KIND_XOR    = 2'd2,
        KIND_MS_XOR = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_RUNT    = 2'd2,
        ST_OVERRUN = 2'd3
    } status_t;

    // One request held in the input stage
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } stage_t;

    // One parse result
    typedef struct packed {
        status_t     status;
        logic        truncated;
        logic [1:0]  msg_class;
        logic [11:0] msg_method;
        kind_t       kind;
        logic [15:0] port;
        logic [31:0] addr;
    } result_t;

endpackage

// ===== sv/stunp_in_stage.sv =====
// Input register stage: holds one payload byte request until the parser takes it.
module stunp_in_stage
    import stunp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] payload_byte,
    input  logic       last_byte,
    input  logic       advance,
    output logic       in_ready,
    output stage_t     stage
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       last_reg;

    // Accept a new request whenever the held one is empty or moves on
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_valid ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on accept
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= payload_byte;
            last_reg <= last_byte;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.data  = data_reg;
    assign stage.last  = last_reg;

endmodule

// ===== sv/stunp_parse_core.sv =====
// Per-packet parse state: header capture, attribute walk, address selection.
module stunp_parse_core
    import stunp_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  stage_t  stage,
    input  logic    advance,
    output result_t result
);

    localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam logic [POS_W-1:0] P_MAX = POS_W'(MAX_PACKET_BYTES);
    localparam logic [POS_W-1:0] P_HDR = POS_W'(HDR_BYTES);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      adv_len_reg, adv_len_next;
    logic [15:0]      type_reg, type_next;
    logic [31:0]      cookie_reg, cookie_next;
    logic [POS_W-1:0] start_reg, start_next;
    logic [15:0]      code_reg, code_next;
    logic [15:0]      alen_reg, alen_next;
    logic [7:0]       family_reg, family_next;
    logic [15:0]      pport_reg, pport_next;
    logic [31:0]      paddr_reg, paddr_next;
    kind_t            best_kind_reg, best_kind_next;
    logic [15:0]      best_port_reg, best_port_next;
    logic [31:0]      best_addr_reg, best_addr_next;
    status_t          stop_reg, stop_next;

    logic [7:0]       b;
    logic [LIM_W-1:0] limit;
    logic [LIM_W-1:0] span;
    logic [POS_W-1:0] rel;
    logic             in_attr;
    logic             halt;
    logic             offer;
    logic             fam_ok;
    logic [31:0]      mask;

    logic [LIM_W-1:0] limit_n;
    logic [POS_W-1:0] end_pos;
    logic [POS_W-1:0] remain;

    assign b      = stage.data;
    assign limit  = LIM_W'(HDR_BYTES) + LIM_W'(adv_len_reg);
    assign span   = limit - LIM_W'(start_reg);
    assign rel    = pos_reg - start_reg;
    assign in_attr = (stop_reg == ST_OK) && (LIM_W'(start_reg) < limit)
                     && (pos_reg >= start_reg);

    // Next-state logic for one payload byte
    always_comb
    begin
        pos_next       = pos_reg;
        adv_len_next   = adv_len_reg;
        type_next      = type_reg;
        cookie_next    = cookie_reg;
        start_next     = start_reg;
        code_next      = code_reg;
        alen_next      = alen_reg;
        family_next    = family_reg;
        pport_next     = pport_reg;
        paddr_next     = paddr_reg;
        best_kind_next = best_kind_reg;
        best_port_next = best_port_reg;
        best_addr_next = best_addr_reg;
        stop_next      = stop_reg;
        halt           = 1'b0;
        offer          = 1'b0;
        fam_ok         = 1'b0;
        mask           = 32'd0;

        if (advance && (pos_reg < P_MAX))
        begin
            pos_next = pos_reg + POS_W'(1);
            if (pos_reg < P_HDR)
            begin
                // Capture header words
                if (pos_reg < POS_W'(2))
                begin
                    type_next = {type_reg[7:0], b};
                end
                else if (pos_reg < POS_W'(4))
                begin
                    adv_len_next = {adv_len_reg[7:0], b};
                end
                else if (pos_reg < POS_W'(8))
                begin
                    cookie_next = {cookie_reg[23:0], b};
                end
            end
            else if (in_attr)
            begin
                // Walk attribute type, length and value
                if (rel == POS_W'(0))
                begin
                    code_next   = {8'd0, b};
                    alen_next   = 16'd0;
                    family_next = 8'd0;
                    pport_next  = 16'd0;
                    paddr_next  = 32'd0;
                end
                else if (rel == POS_W'(1))
                begin
                    code_next = {code_reg[7:0], b};
                end
                else if (rel == POS_W'(2))
                begin
                    alen_next = {8'd0, b};
                end
                else if (rel == POS_W'(3))
                begin
                    alen_next = {alen_reg[7:0], b};
                    if (span < LIM_W'(4))
                    begin
                        stop_next = ST_RUNT;
                        halt      = 1'b1;
                    end
                    else if ((LIM_W'(alen_next) + LIM_W'(4)) > span)
                    begin
                        stop_next = ST_OVERRUN;
                        halt      = 1'b1;
                    end
                end
                else if (rel == POS_W'(5))
                begin
                    family_next = b;
                end
                else if ((rel == POS_W'(6)) || (rel == POS_W'(7)))
                begin
                    pport_next = {pport_reg[7:0], b};
                end
                else if ((rel >= POS_W'(8)) && (rel <= POS_W'(11)))
                begin
                    paddr_next = {paddr_reg[23:0], b};
                end

                // Offer a finished attribute and step to the next one
                if (!halt && (rel >= POS_W'(3))
                    && (LIM_W'(rel) == (LIM_W'(alen_next) + LIM_W'(3))))
                begin
                    start_next = pos_reg + POS_W'(1);
                    fam_ok     = (alen_next >= 16'd8) && (family_next == 8'd1);
                    mask       = cookie_reg;
                    case (code_reg)
                        AT_MAPPED:
                        begin
                            offer = fam_ok && (best_kind_reg != KIND_XOR)
                                    && (best_kind_reg != KIND_MS_XOR);
                            mask  = 32'd0;
                            if (offer)
                            begin
                                best_kind_next = KIND_MAPPED;
                            end
                        end
                        AT_MS_XOR:
                        begin
                            offer = fam_ok && (best_kind_reg != KIND_XOR);
                            if (offer)
                            begin
                                best_kind_next = KIND_MS_XOR;
                            end
                        end
                        AT_XOR:
                        begin
                            offer = fam_ok;
                            if (offer)
                            begin
                                best_kind_next = KIND_XOR;
                            end
                        end
                        default:
                        begin
                            offer = 1'b0;
                        end
                    endcase
                    if (offer)
                    begin
                        best_port_next = pport_next ^ mask[31:16];
                        best_addr_next = paddr_next ^ mask;
                    end
                end
            end
        end
    end

    // Build the result from the state after this byte
    assign limit_n = LIM_W'(HDR_BYTES) + LIM_W'(adv_len_next);
    assign end_pos = (limit_n < LIM_W'(pos_next)) ? limit_n[POS_W-1:0] : pos_next;
    assign remain  = end_pos - start_next;

    always_comb
    begin
        result = '0;
        if (pos_next < P_HDR)
        begin
            result.status = ST_SHORT;
        end
        else
        begin
            result.status = stop_next;
            if ((stop_next == ST_OK) && (start_next < end_pos))
            begin
                result.status = (remain < POS_W'(4)) ? ST_RUNT : ST_OVERRUN;
            end
            result.truncated  = LIM_W'(adv_len_next) > LIM_W'(pos_next - P_HDR);
            result.msg_class  = {type_next[8], type_next[4]};
            result.msg_method = {type_next[13:9], type_next[7:5], type_next[3:0]};
            result.kind       = best_kind_next;
            result.port       = best_port_next;
            result.addr       = best_addr_next;
        end
    end

    // Advance state; clear it at the end of a packet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            adv_len_reg   <= '0;
            type_reg      <= '0;
            cookie_reg    <= '0;
            start_reg     <= P_HDR;
            code_reg      <= '0;
            alen_reg      <= '0;
            family_reg    <= '0;
            pport_reg     <= '0;
            paddr_reg     <= '0;
            best_kind_reg <= KIND_NONE;
            best_port_reg <= '0;
            best_addr_reg <= '0;
            stop_reg      <= ST_OK;
        end
        else if (advance)
        begin
            if (stage.last)
            begin
                pos_reg       <= '0;
                adv_len_reg   <= '0;
                type_reg      <= '0;
                cookie_reg    <= '0;
                start_reg     <= P_HDR;
                code_reg      <= '0;
                alen_reg      <= '0;
                family_reg    <= '0;
                pport_reg     <= '0;
                paddr_reg     <= '0;
                best_kind_reg <= KIND_NONE;
                best_port_reg <= '0;
                best_addr_reg <= '0;
                stop_reg      <= ST_OK;
            end
            else
            begin
                pos_reg       <= pos_next;
                adv_len_reg   <= adv_len_next;
                type_reg      <= type_next;
                cookie_reg    <= cookie_next;
                start_reg     <= start_next;
                code_reg      <= code_next;
                alen_reg      <= alen_next;
                family_reg    <= family_next;
                pport_reg     <= pport_next;
                paddr_reg     <= paddr_next;
                best_kind_reg <= best_kind_next;
                best_port_reg <= best_port_next;
                best_addr_reg <= best_addr_next;
                stop_reg      <= stop_next;
            end
        end
    end

endmodule

// ===== sv/stun_response_mapped_address_parser.sv =====
// A last byte passes the input stage, then its result goes to the result register.
// Throughput: one payload byte per cycle; the parse state updates once per byte.
// The result register frees the input side: bytes keep flowing while a result waits,
// and only a last byte stalls if the previous result has not yet been taken.
// Reset: asynchronous active-low rst_n clears the input and result valid flags and
// the parse state; the parser is ready in the first cycle after reset.
module stun_response_mapped_address_parser
    import stunp_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  payload_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  parse_status,
    output logic        length_truncated,
    output logic [1:0]  message_class,
    output logic [11:0] message_method,
    output logic [1:0]  address_kind,
    output logic [15:0] mapped_port,
    output logic [31:0] mapped_address
);

    stage_t  stage;
    result_t result;
    result_t res_reg;
    logic    out_valid_reg;
    logic    slot_free;
    logic    advance;

    // Move the held byte on unless it ends a packet and the result slot is full
    assign slot_free = !out_valid_reg || out_ready;
    assign advance   = stage.valid && (!stage.last || slot_free);

    stunp_in_stage u_in_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .payload_byte (payload_byte),
        .last_byte    (last_byte),
        .advance      (advance),
        .in_ready     (in_ready),
        .stage        (stage)
    );

    stunp_parse_core #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parse_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .stage   (stage),
        .advance (advance),
        .result  (result)
    );

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            out_valid_reg <= advance && stage.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage.last)
        begin
            res_reg <= result;
        end
    end

    assign out_valid        = out_valid_reg;
    assign parse_status     = res_reg.status;
    assign length_truncated = res_reg.truncated;
    assign message_class    = res_reg.msg_class;
    assign message_method   = res_reg.msg_method;
    assign address_kind     = res_reg.kind;
    assign mapped_port      = res_reg.port;
    assign mapped_address   = res_reg.addr;

endmodule

// ===== sv/stunp_checker.sv =====
// Port-level checks for the STUN mapped-address parser, bound to the top level.
module stunp_checker
    import stunp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  payload_byte,
    input logic        last_byte,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  parse_status,
    input logic        length_truncated,
    input logic [1:0]  message_class,
    input logic [11:0] message_method,
    input logic [1:0]  address_kind,
    input logic [15:0] mapped_port,
    input logic [31:0] mapped_address
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(parse_status)
            && $stable(address_kind) && $stable(mapped_address) && $stable(mapped_port))
        else $error("stalled result changed");

    // Never stall input while the result slot is empty
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result slot");

    // A short packet reports nothing else
    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (parse_status == ST_SHORT) |-> (address_kind == KIND_NONE)
            && (mapped_port == 16'd0) && (mapped_address == 32'd0)
            && (message_class == 2'd0) && (message_method == 12'd0)
            && !length_truncated)
        else $error("short packet result not cleared");

    // No address chosen means zero port and address
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (address_kind == KIND_NONE) |-> (mapped_port == 16'd0)
            && (mapped_address == 32'd0))
        else $error("address reported without a kind");

    // A new result follows an accepted last byte
    a_rose_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && last_byte, 2))
        else $error("result without a last byte");

endmodule

bind stun_response_mapped_address_parser stunp_checker u_stunp_checker (.*);

// ===== bench/testbench.sv =====
// Self-checking testbench for the STUN mapped-address parser: directed and random packets.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import stunp_pkg::*;

    localparam int          PKT_LIMIT    = MAX_PACKET_BYTES_DEF;
    localparam int          RANDOM_BYTES = 1250;
    localparam int          DRAIN_LIMIT  = 2000;
    localparam logic [15:0] BINDING_OK   = 16'h0101;
    localparam logic [15:0] BINDING_ERR  = 16'h0111;
    localparam logic [31:0] MAGIC_COOKIE = 32'h2112_A442;
    localparam logic [15:0] AT_USERNAME  = 16'h0006;
    localparam logic [15:0] AT_SOFTWARE  = 16'h8022;
    localparam logic [7:0]  FAMILY_IPV4  = 8'd1;
    localparam logic [7:0]  FAMILY_IPV6  = 8'd2;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  payload_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  parse_status;
    logic        length_truncated;
    logic [1:0]  message_class;
    logic [11:0] message_method;
    logic [1:0]  address_kind;
    logic [15:0] mapped_port;
    logic [31:0] mapped_address;

    // Parser state as the predictor sees it
    logic [10:0] ps_pos;
    logic [15:0] ps_adv;
    logic [15:0] ps_type;
    logic [31:0] ps_cookie;
    logic [10:0] ps_attr_at;
    logic [15:0] ps_attr_code;
    logic [15:0] ps_attr_len;
    logic [7:0]  ps_family;
    logic [15:0] ps_port;
    logic [31:0] ps_addr;
    kind_t       ps_best_kind;
    logic [15:0] ps_best_port;
    logic [31:0] ps_best_addr;
    status_t     ps_stop;

    result_t     expected_q[$];
    logic [7:0]  frame[$];

    bit          in_steady;
    bit          out_steady;
    int unsigned fail_count;
    int unsigned bytes_sent;
    int unsigned packets_sent;
    int unsigned results_seen;
    int unsigned kinds_seen[4];

    always #10 clk = ~clk;

    stun_response_mapped_address_parser #(
        .MAX_PACKET_BYTES (PKT_LIMIT)
    ) u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .payload_byte     (payload_byte),
        .last_byte        (last_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .parse_status     (parse_status),
        .length_truncated (length_truncated),
        .message_class    (message_class),
        .message_method   (message_method),
        .address_kind     (address_kind),
        .mapped_port      (mapped_port),
        .mapped_address   (mapped_address)
    );

    // Return the per-packet state to its reset values
    function automatic void parser_clear();
        ps_pos       = '0;
        ps_adv       = '0;
        ps_type      = '0;
        ps_cookie    = '0;
        ps_attr_at   = 11'(HDR_BYTES);
        ps_attr_code = '0;
        ps_attr_len  = '0;
        ps_family    = '0;
        ps_port      = '0;
        ps_addr      = '0;
        ps_best_kind = KIND_NONE;
        ps_best_port = '0;
        ps_best_addr = '0;
        ps_stop      = ST_OK;
    endfunction

    // Offer a completed attribute to the address choice; XOR beats MS-XOR beats plain
    function automatic void choose_address();
        kind_t       cand;
        logic [31:0] mask;
        mask = ps_cookie;
        if (ps_attr_code == AT_MAPPED)
        begin
            if (ps_best_kind == KIND_XOR || ps_best_kind == KIND_MS_XOR)
                return;
            cand = KIND_MAPPED;
            mask = '0;
        end
        else if (ps_attr_code == AT_MS_XOR)
        begin
            if (ps_best_kind == KIND_XOR)
                return;
            cand = KIND_MS_XOR;
        end
        else if (ps_attr_code == AT_XOR)
            cand = KIND_XOR;
        else
            return;
        if (ps_attr_len < 16'd8 || ps_family != FAMILY_IPV4)
            return;
        ps_best_kind = cand;
        ps_best_port = ps_port ^ mask[31:16];
        ps_best_addr = ps_addr ^ mask;
    endfunction

    // Fold one payload byte at position p into the header or the attribute walk
    function automatic void absorb_byte(int unsigned p, logic [7:0] b);
        int unsigned msg_end;
        int unsigned rel;
        if (p < HDR_BYTES)
        begin
            if (p < 2)
                ps_type = {ps_type[7:0], b};
            else if (p < 4)
                ps_adv = {ps_adv[7:0], b};
            else if (p < 8)
                ps_cookie = {ps_cookie[23:0], b};
            return;
        end
        if (ps_stop != ST_OK)
            return;
        msg_end = HDR_BYTES + ps_adv;
        if (ps_attr_at >= msg_end || p < ps_attr_at)
            return;
        rel = p - ps_attr_at;
        if (rel == 0)
        begin
            ps_attr_code = {8'h00, b};
            ps_attr_len  = '0;
            ps_family    = '0;
            ps_port      = '0;
            ps_addr      = '0;
        end
        else if (rel == 1)
            ps_attr_code = {ps_attr_code[7:0], b};
        else if (rel == 2)
            ps_attr_len = {8'h00, b};
        else if (rel == 3)
        begin
            ps_attr_len = {ps_attr_len[7:0], b};
            if (msg_end - ps_attr_at < 4)
            begin
                ps_stop = ST_RUNT;
                return;
            end
            if (ps_attr_len + 4 > msg_end - ps_attr_at)
            begin
                ps_stop = ST_OVERRUN;
                return;
            end
        end
        else if (rel == 5)
            ps_family = b;
        else if (rel == 6 || rel == 7)
            ps_port = {ps_port[7:0], b};
        else if (rel >= 8 && rel <= 11)
            ps_addr = {ps_addr[23:0], b};
        if (rel >= 3 && rel == 3 + ps_attr_len)
        begin
            choose_address();
            ps_attr_at = 11'(ps_attr_at + 4 + ps_attr_len);
        end
    endfunction

    // Advance the predictor by one accepted request; queue a result on the last byte
    function automatic void predict_byte(logic [7:0] b, logic lst);
        int unsigned p;
        int unsigned got;
        int unsigned msg_end;
        int unsigned stop_at;
        result_t     r;
        p = 32'(ps_pos);
        if (p < PKT_LIMIT)
        begin
            absorb_byte(p, b);
            ps_pos = 11'(p + 1);
        end
        if (!lst)
            return;
        got = 32'(ps_pos);
        r = '0;
        if (got < HDR_BYTES)
            r.status = ST_SHORT;
        else
        begin
            msg_end     = HDR_BYTES + ps_adv;
            r.truncated = (ps_adv > got - HDR_BYTES);
            stop_at     = (msg_end < got) ? msg_end : got;
            r.status    = ps_stop;
            if (ps_stop == ST_OK && ps_attr_at < stop_at)
                r.status = (stop_at - ps_attr_at < 4) ? ST_RUNT : ST_OVERRUN;
            r.msg_class  = {ps_type[8], ps_type[4]};
            r.msg_method = {ps_type[13:9], ps_type[7:5], ps_type[3:0]};
            r.kind       = ps_best_kind;
            r.port       = ps_best_port;
            r.addr       = ps_best_addr;
        end
        expected_q.push_back(r);
        parser_clear();
    endfunction

    // Packet construction helpers
    function automatic void start_frame(logic [15:0] mtype, logic [31:0] cookie);
        frame.delete();
        frame.push_back(mtype[15:8]);
        frame.push_back(mtype[7:0]);
        frame.push_back(8'h00);
        frame.push_back(8'h00);
        frame.push_back(cookie[31:24]);
        frame.push_back(cookie[23:16]);
        frame.push_back(cookie[15:8]);
        frame.push_back(cookie[7:0]);
        repeat (12) frame.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void set_length(logic [15:0] n);
        frame[2] = n[15:8];
        frame[3] = n[7:0];
    endfunction

    function automatic void seal_frame();
        set_length(16'(frame.size() - HDR_BYTES));
    endfunction

    function automatic void pad_frame(int unsigned n);
        repeat (n) frame.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void cut_frame(int unsigned n);
        while (frame.size() > n)
            void'(frame.pop_back());
    endfunction

    // Append type, length and nbytes of value: reserved, family, port, address, filler
    function automatic void add_attr(logic [15:0] code, logic [15:0] len, int unsigned nbytes,
                                     logic [7:0] fam, logic [15:0] port, logic [31:0] addr);
        logic [7:0] val[8];
        val[0] = 8'($urandom_range(0, 255));
        val[1] = fam;
        val[2] = port[15:8];
        val[3] = port[7:0];
        val[4] = addr[31:24];
        val[5] = addr[23:16];
        val[6] = addr[15:8];
        val[7] = addr[7:0];
        frame.push_back(code[15:8]);
        frame.push_back(code[7:0]);
        frame.push_back(len[15:8]);
        frame.push_back(len[7:0]);
        for (int unsigned i = 0; i < nbytes; i++)
            frame.push_back(i < 8 ? val[i] : 8'($urandom_range(0, 255)));
    endfunction

    // Send one request, idling a random number of cycles first unless in_steady is set
    task automatic send_byte(input logic [7:0] b, input logic lst);
        int unsigned gap;
        gap = in_steady ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        payload_byte <= b;
        last_byte    <= lst;
        do
            @(posedge clk);
        while (!in_ready);
        predict_byte(b, lst);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++)
            send_byte(frame[i], i == frame.size() - 1);
        packets_sent++;
    endtask

    // Hold the input until every expected result has come out or the drain limit runs out
    task automatic settle();
        int unsigned waited;
        waited = 0;
        in_valid <= 1'b0;
        while (expected_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic test_short_packets();
        frame.delete();
        frame.push_back(8'hff);
        send_frame();
        start_frame(16'hffff, 32'hffff_ffff);
        cut_frame(HDR_BYTES - 1);
        send_frame();
        start_frame(16'h0000, 32'h0000_0000);
        cut_frame(2);
        send_frame();
        settle();
    endtask

    task automatic test_header_fields();
        start_frame(16'hffff, 32'hffff_ffff);
        send_frame();
        start_frame(16'h0000, 32'h0000_0000);
        send_frame();
        start_frame(BINDING_ERR, MAGIC_COOKIE);
        send_frame();
        start_frame(16'($urandom_range(0, 65535)), MAGIC_COOKIE);
        send_frame();
        settle();
    endtask

    task automatic test_address_selection();
        start_frame(BINDING_OK, MAGIC_COOKIE);
        add_attr(AT_MAPPED, 8, 8, FAMILY_IPV4, 16'hffff, 32'hffff_ffff);
        seal_frame();
        send_frame();
        // plain, then XOR wins, then plain again loses
        start_frame(BINDING_OK, MAGIC_COOKIE);
        add_attr(AT_MAPPED, 8, 8, FAMILY_IPV4, 16'h0000, 32'h0000_0000);
        add_attr(AT_XOR, 8, 8, FAMILY_IPV4, 16'($urandom_range(0, 65535)), $urandom);
        add_attr(AT_MAPPED, 8, 8, FAMILY_IPV4, 16'($urandom_range(0, 65535)), $urandom);
        seal_frame();
        send_frame();
        // MS-XOR, then XOR wins, then MS-XOR loses
        start_frame(BINDING_OK, $urandom);
        add_attr(AT_MS_XOR, 8, 8, FAMILY_IPV4, 16'($urandom_range(0, 65535)), $urandom);
        add_attr(AT_XOR, 8, 8, FAMILY_IPV4, 16'($urandom_range(0, 65535)), $urandom);
        add_attr(AT_MS_XOR, 8, 8, FAMILY_IPV4, 16'($urandom_range(0, 65535)), $urandom);
        seal_frame();
        send_frame();
        // plain, then MS-XOR wins, then plain loses
        start_frame(BINDING_OK, MAGIC_COOKIE);
        add_attr(AT_MAPPED, 8, 8, FAMILY_IPV4, 16'($urandom_range(0, 65535)), $urandom);
        add_attr(AT_MS_XOR, 8, 8, FAMILY_IPV4, 16'($urandom_range(0, 65535)), $urandom);
        add_attr(AT_MAPPED, 8, 8, FAMILY_IPV4, 16'($urandom_range(0, 65535)), $urandom);
        seal_frame();
        send_frame();
        // all-ones cookie unmasks zeros to all ones
        start_frame(BINDING_OK, 32'hffff_ffff);
        add_attr(AT_XOR, 8, 8, FAMILY_IPV4, 16'h0000, 32'h0000_0000);
        seal_frame();
        send_frame();
        settle();
    endtask

    task automatic test_rejected_attributes();
        start_frame(BINDING_OK, MAGIC_COOKIE);
        add_attr(AT_XOR, 7, 7, FAMILY_IPV4, 16'($urandom_range(0, 65535)), $urandom);
        add_attr(AT_MS_XOR, 8, 8, FAMILY_IPV6, 16'($urandom_range(0, 65535)), $urandom);
        add_attr(AT_MAPPED, 20, 20, FAMILY_IPV6, 16'($urandom_range(0, 65535)), $urandom);
        add_attr(AT_SOFTWARE, 5, 5, FAMILY_IPV4, 16'($urandom_range(0, 65535)), $urandom);
        add_attr(AT_XOR, 0, 0, FAMILY_IPV4, 16'h0000, 32'h0000_0000);
        seal_frame();
        send_frame();
        // long value: bytes past the address are ignored
        start_frame(BINDING_OK, MAGIC_COOKIE);
        add_attr(AT_USERNAME, 12, 12, FAMILY_IPV4, 16'($urandom_range(0, 65535)), $urandom);
        add_attr(AT_MAPPED, 12, 12, FAMILY_IPV4, 16'($urandom_range(0, 65535)), $urandom);
        seal_frame();
        send_frame();
        settle();
    endtask

    task automatic test_walk_errors();
        // runt left at the message end
        start_frame(BINDING_OK, MAGIC_COOKIE);
        add_attr(AT_MAPPED, 8, 8, FAMILY_IPV4, 16'($urandom_range(0, 65535)), $urandom);
        set_length(16'(frame.size() - HDR_BYTES + 3));
        pad_frame(3);
        send_frame();
        // runt found during the walk
        start_frame(BINDING_OK, MAGIC_COOKIE);
        set_length(16'd2);
        pad_frame(8);
        send_frame();
        // overrun after a good address; the address stays
        start_frame(BINDING_OK, MAGIC_COOKIE);
        add_attr(AT_XOR, 8, 8, FAMILY_IPV4, 16'($urandom_range(0, 65535)), $urandom);
        add_attr(AT_MAPPED, 100, 64, FAMILY_IPV4, 16'($urandom_range(0, 65535)), $urandom);
        seal_frame();
        send_frame();
        start_frame(BINDING_OK, MAGIC_COOKIE);
        add_attr(AT_SOFTWARE, 16'hffff, 8, FAMILY_IPV4, 16'hffff, 32'hffff_ffff);
        seal_frame();
        send_frame();
        settle();
    endtask

    task automatic test_length_clipping();
        start_frame(BINDING_OK, MAGIC_COOKIE);
        add_attr(AT_MS_XOR, 8, 8, FAMILY_IPV4, 16'($urandom_range(0, 65535)), $urandom);
        seal_frame();
        set_length(16'd200);
        send_frame();
        start_frame(BINDING_OK, MAGIC_COOKIE);
        add_attr(AT_MAPPED, 8, 8, FAMILY_IPV4, 16'($urandom_range(0, 65535)), $urandom);
        set_length(16'hffff);
        send_frame();
        // an attribute past the message end is ignored
        start_frame(BINDING_OK, MAGIC_COOKIE);
        add_attr(AT_MAPPED, 8, 8, FAMILY_IPV4, 16'($urandom_range(0, 65535)), $urandom);
        seal_frame();
        add_attr(AT_XOR, 8, 8, FAMILY_IPV4, 16'($urandom_range(0, 65535)), $urandom);
        send_frame();
        settle();
    endtask

    task automatic test_oversized_packet();
        in_steady = 1'b1;
        start_frame(BINDING_OK, MAGIC_COOKIE);
        add_attr(AT_XOR, 8, 8, FAMILY_IPV4, 16'($urandom_range(0, 65535)), $urandom);
        add_attr(AT_USERNAME, 960, 960, FAMILY_IPV4, 16'h0000, 32'h0000_0000);
        add_attr(AT_MAPPED, 8, 8, FAMILY_IPV4, 16'($urandom_range(0, 65535)), $urandom);
        add_attr(AT_MS_XOR, 8, 8, FAMILY_IPV4, 16'($urandom_range(0, 65535)), $urandom);
        add_attr(AT_XOR, 8, 8, FAMILY_IPV4, 16'($urandom_range(0, 65535)), $urandom);
        seal_frame();
        pad_frame(4);
        send_frame();
        in_steady = 1'b0;
        settle();
    endtask

    // Mostly well-formed responses with random content, plus noise and broken packets
    task automatic test_random_packets();
        int unsigned start_bytes;
        int unsigned pick;
        int unsigned body;
        int unsigned shave;
        logic [15:0] code;
        logic [15:0] alen;
        logic [7:0]  fam;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES)
        begin
            in_steady  = ($urandom_range(0, 4) == 0);
            out_steady = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                frame.delete();
                pad_frame($urandom_range(1, 40));
            end
            else
            begin
                start_frame(($urandom_range(0, 9) < 7) ? BINDING_OK : 16'($urandom_range(0, 65535)),
                            ($urandom_range(0, 9) < 7) ? MAGIC_COOKIE : $urandom);
                repeat ($urandom_range(0, 4))
                begin
                    case ($urandom_range(0, 3))
                        0:       code = AT_MAPPED;
                        1:       code = AT_XOR;
                        2:       code = AT_MS_XOR;
                        default: code = 16'($urandom_range(0, 65535));
                    endcase
                    fam = ($urandom_range(0, 99) < 85) ? FAMILY_IPV4 : 8'($urandom_range(0, 255));
                    body = $urandom_range(0, 99);
                    if (body < 70)
                        alen = 16'd8;
                    else if (body < 80)
                        alen = 16'd12;
                    else if (body < 85)
                    begin
                        alen = 16'd20;
                        fam  = FAMILY_IPV6;
                    end
                    else if (body < 97)
                        alen = 16'($urandom_range(0, 15));
                    else
                        alen = 16'($urandom_range(0, 65535));
                    add_attr(code, alen, (alen > 24) ? 24 : alen, fam,
                             16'($urandom_range(0, 65535)), $urandom);
                end
                seal_frame();
                body = frame.size() - HDR_BYTES;
                pick = $urandom_range(0, 99);
                if (pick >= 95)
                    set_length(16'($urandom_range(0, 65535)));
                else if (pick >= 88)
                begin
                    shave = $urandom_range(1, 6);
                    set_length(16'((shave > body) ? 0 : body - shave));
                end
                else if (pick >= 78)
                    set_length(16'(body + $urandom_range(1, 8)));
                if ($urandom_range(0, 4) == 0)
                    pad_frame($urandom_range(1, 6));
                if ($urandom_range(0, 9) == 0)
                    cut_frame($urandom_range(HDR_BYTES, frame.size()));
                if ($urandom_range(0, 99) < 7)
                    cut_frame($urandom_range(1, HDR_BYTES - 1));
            end
            send_frame();
            if ($urandom_range(0, 11) == 0)
                settle();
        end
        in_steady  = 1'b0;
        out_steady = 1'b0;
        settle();
    endtask

    // Take results with a random stall before each one unless out_steady is set
    initial
    begin : result_sink
        int unsigned stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = out_steady ? 0 : $urandom_range(0, 15);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Compare each result taken with the oldest prediction
    always @(posedge clk)
    begin : result_check
        result_t seen;
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen.status     = status_t'(parse_status);
            seen.truncated  = length_truncated;
            seen.msg_class  = message_class;
            seen.msg_method = message_method;
            seen.kind       = kind_t'(address_kind);
            seen.port       = mapped_port;
            seen.addr       = mapped_address;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: result with none expected: st=%0d kind=%0d port=%h addr=%h",
                             $realtime, seen.status, seen.kind, seen.port, seen.addr);
            end
            else
            begin
                want = expected_q.pop_front();
                kinds_seen[want.kind]++;
                if (seen.status !== want.status || seen.truncated !== want.truncated ||
                    seen.msg_class !== want.msg_class || seen.msg_method !== want.msg_method ||
                    seen.kind !== want.kind || seen.port !== want.port ||
                    seen.addr !== want.addr)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("%0t: mismatch exp st=%0d tr=%0d cls=%0d meth=%h kind=%0d port=%h addr=%h",
                                 $realtime, want.status, want.truncated, want.msg_class,
                                 want.msg_method, want.kind, want.port, want.addr);
                        $display("%0t:          got st=%0d tr=%0d cls=%0d meth=%h kind=%0d port=%h addr=%h",
                                 $realtime, seen.status, seen.truncated, seen.msg_class,
                                 seen.msg_method, seen.kind, seen.port, seen.addr);
                    end
                end
            end
        end
    end

    // Stop a hung run
    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        in_valid     = 1'b0;
        payload_byte = 8'h00;
        last_byte    = 1'b0;
        in_steady    = 1'b0;
        out_steady   = 1'b0;
        fail_count   = 0;
        bytes_sent   = 0;
        packets_sent = 0;
        results_seen = 0;
        parser_clear();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_packets();
        test_header_fields();
        test_address_selection();
        test_rejected_attributes();
        test_walk_errors();
        test_length_clipping();
        test_oversized_packet();
        test_random_packets();

        if (expected_q.size() != 0)
        begin
            $display("%0d expected results never arrived", expected_q.size());
            fail_count += expected_q.size();
        end
        $display("covered %0d packets (%0d payload bytes), %0d results compared, %0d failures",
                 packets_sent, bytes_sent, results_seen, fail_count);
        $display("address kinds predicted: none %0d, mapped %0d, xor %0d, ms-xor %0d",
                 kinds_seen[0], kinds_seen[1], kinds_seen[2], kinds_seen[3]);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
